// ----- rtl/core/urkf_pkg.sv -----
package urkf_pkg;

   typedef logic [18:0] dist_type;
   typedef logic [23:0] noise_type;
   typedef logic [23:0] est_type;
   typedef logic [16:0] hreg_type;
   typedef logic [18:0] thresh_type;
   typedef logic [31:0] cov_type;
   typedef logic [31:0] gain_type;
   typedef logic [47:0] num_type;
   typedef logic [32:0] factor_type;
   typedef logic [15:0] idx_type;
   typedef logic [63:0] wide_type;
   typedef logic [32:0] mul_a_type;
   typedef logic [31:0] mul_b_type;
   typedef logic [64:0] mul_full_type;
   typedef logic [5:0]  cnt_type;
   typedef logic [3:0]  csr_addr_type;
   typedef logic [31:0] csr_data_type;
   typedef logic [1:0]  reg_index_type;

   localparam reg_index_type REG_MEAS_NOISE_R        = 2'd0;
   localparam reg_index_type REG_PROCESS_NOISE_Q     = 2'd1;
   localparam reg_index_type REG_MEAS_MAP_H          = 2'd2;
   localparam reg_index_type REG_COLLISION_THRESHOLD = 2'd3;

   localparam int KF             = 16;
   localparam int RAW_MULT       = 17;
   localparam int NOISE_RESET    = 10;
   localparam int THRESH_RESET   = 5;
   localparam int H_RESET        = 1;
   localparam int RAW_RECIP_SHIFT = 39;

   localparam dist_type  DIST_MAX    = 19'd285212;
   localparam wide_type  RAW_DIVISOR = 64'd1000;
   localparam wide_type  RAW_ROUND   = 64'd500;
   localparam wide_type  EST_MAX     = 64'h0000_0000_00FF_FFFF;
   localparam wide_type  RAW_RECIP   =
      ((64'd1 << RAW_RECIP_SHIFT) + RAW_DIVISOR - 64'd1) / RAW_DIVISOR;
   localparam wide_type  RAW_LIMIT   = RAW_DIVISOR * (64'(DIST_MAX) + 64'd1) - RAW_ROUND;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL_D,
      S_MUL_RAW,
      S_RAW,
      S_MUL_PH,
      S_MUL_HH,
      S_MUL_HHP,
      S_GAIN_START,
      S_GAIN_DIV,
      S_MUL_HX,
      S_MAG,
      S_MUL_KMAG,
      S_EST,
      S_MUL_KH,
      S_FACTOR,
      S_MUL_FP,
      S_COV,
      S_DONE
   } state_type;

endpackage

// ----- rtl/core/ultrasonic_range_kalman_filter.sv -----
// Ultrasonic range filter with a scalar Kalman step.
// Input channel req_*: one echo pulse width in microseconds per transfer.
// Result channel rsp_*: raw distance, filtered distance, collision flag and a
// wrapping sample index, one result per input, in order.
// csr_*: APB-style register port, pready always high, registers at 4*index:
// R, Q, H and the collision threshold. Write only while the block is idle.
// Each item runs through one shared multiplier and one radix-2 divider under
// a sequencer: a reciprocal multiplication for the distance scaling, a
// restoring divide for the gain, skipped when the gain denominator is zero,
// and the multiplier for the products. The sequencer takes no new item until
// it has finished the current one.
// req_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next item may be taken meanwhile. A stalled
// receiver holds the result; a following result waits in the sequencer.
// Synchronous reset restores the register defaults, clears the estimate, the
// covariance and the sample count, and drops any pending result.
module ultrasonic_range_kalman_filter #(
   parameter int DURATION_BITS = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [DURATION_BITS-1:0] req_echo_duration_us,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output urkf_pkg::dist_type     rsp_raw_distance,
   output urkf_pkg::dist_type     rsp_filtered_distance,
   output logic                   rsp_collision_flag,
   output urkf_pkg::idx_type      rsp_sample_index,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  urkf_pkg::csr_addr_type csr_paddr,
   input  urkf_pkg::csr_data_type csr_pwdata,
   output urkf_pkg::csr_data_type csr_prdata,
   output logic                   csr_pready
);

   localparam int COV_SHIFT = urkf_pkg::KF + FRAC_BITS;
   localparam urkf_pkg::mul_a_type RAW_SCALE =
      urkf_pkg::mul_a_type'(urkf_pkg::RAW_MULT) << FRAC_BITS;
   localparam urkf_pkg::wide_type RAW_SAT_D =
      (urkf_pkg::RAW_LIMIT + urkf_pkg::wide_type'(RAW_SCALE) - 64'd1) /
      urkf_pkg::wide_type'(RAW_SCALE);
   localparam urkf_pkg::wide_type GAIN_ROUND = urkf_pkg::wide_type'(1) << (urkf_pkg::KF - 1);
   localparam urkf_pkg::wide_type COV_ONE = urkf_pkg::wide_type'(1) << COV_SHIFT;
   localparam urkf_pkg::wide_type COV_ROUND = urkf_pkg::wide_type'(1) << (COV_SHIFT - 1);
   localparam urkf_pkg::noise_type NOISE_RST =
      urkf_pkg::noise_type'(urkf_pkg::NOISE_RESET) << FRAC_BITS;
   localparam urkf_pkg::hreg_type H_RST = urkf_pkg::hreg_type'(urkf_pkg::H_RESET) << FRAC_BITS;
   localparam urkf_pkg::thresh_type THRESH_RST =
      urkf_pkg::thresh_type'(urkf_pkg::THRESH_RESET) << FRAC_BITS;

   urkf_pkg::state_type state_ff, state_in;

   logic [DURATION_BITS-1:0] d_ff, d_in;
   urkf_pkg::idx_type     idx_ff, idx_in;
   urkf_pkg::idx_type     count_ff, count_in;
   urkf_pkg::dist_type    raw_ff, raw_in;
   urkf_pkg::num_type     num_ff, num_in;
   urkf_pkg::wide_type    rem_ff, rem_in;
   urkf_pkg::wide_type    quo_ff, quo_in;
   urkf_pkg::wide_type    den_ff, den_in;
   urkf_pkg::cnt_type     div_cnt_ff, div_cnt_in;
   urkf_pkg::gain_type    k_ff, k_in;
   urkf_pkg::mul_b_type   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   urkf_pkg::est_type     est_ff, est_in;
   urkf_pkg::factor_type  factor_ff, factor_in;
   urkf_pkg::cov_type     cov_ff, cov_in;
   urkf_pkg::wide_type    mul_ff, mul_in;

   urkf_pkg::noise_type   r_ff, r_in;
   urkf_pkg::noise_type   q_ff, q_in;
   urkf_pkg::hreg_type    h_ff, h_in;
   urkf_pkg::thresh_type  thr_ff, thr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   urkf_pkg::dist_type    rsp_raw_ff, rsp_raw_in;
   urkf_pkg::dist_type    rsp_filt_ff, rsp_filt_in;
   logic                  rsp_coll_ff, rsp_coll_in;
   urkf_pkg::idx_type     rsp_idx_ff, rsp_idx_in;

   urkf_pkg::mul_a_type    mul_a;
   urkf_pkg::mul_b_type    mul_b;
   urkf_pkg::mul_full_type mul_full;
   urkf_pkg::wide_type     rem_shift;
   logic                   div_ge;
   urkf_pkg::wide_type     quo_next;
   urkf_pkg::wide_type     rem_next;
   logic                   div_last;
   urkf_pkg::wide_type     den_sum;
   urkf_pkg::wide_type     raw_quo;
   logic                   raw_sat;
   urkf_pkg::wide_type     raw_wide;
   urkf_pkg::wide_type     hx;
   urkf_pkg::wide_type     diff;
   urkf_pkg::wide_type     delta;
   urkf_pkg::wide_type     est_wide;
   urkf_pkg::wide_type     est_sum;
   urkf_pkg::wide_type     np;
   urkf_pkg::reg_index_type csr_index;
   logic                   csr_write;
   logic                   accept;
   logic                   rsp_load;

   assign csr_index = csr_paddr[3:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         urkf_pkg::REG_MEAS_NOISE_R:        csr_prdata = urkf_pkg::csr_data_type'(r_ff);
         urkf_pkg::REG_PROCESS_NOISE_Q:     csr_prdata = urkf_pkg::csr_data_type'(q_ff);
         urkf_pkg::REG_MEAS_MAP_H:          csr_prdata = urkf_pkg::csr_data_type'(h_ff);
         urkf_pkg::REG_COLLISION_THRESHOLD: csr_prdata = urkf_pkg::csr_data_type'(thr_ff);
         default:                           csr_prdata = '0;
      endcase
   end

   always_comb begin
      r_in   = r_ff;
      q_in   = q_ff;
      h_in   = h_ff;
      thr_in = thr_ff;
      if (csr_write) begin
         case (csr_index)
            urkf_pkg::REG_MEAS_NOISE_R:        r_in   = csr_pwdata[23:0];
            urkf_pkg::REG_PROCESS_NOISE_Q:     q_in   = csr_pwdata[23:0];
            urkf_pkg::REG_MEAS_MAP_H:          h_in   = {1'b0, csr_pwdata[15:0]};
            urkf_pkg::REG_COLLISION_THRESHOLD: thr_in = csr_pwdata[18:0];
            default: begin
            end
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         urkf_pkg::S_MUL_D: begin
            mul_a = RAW_SCALE;
            mul_b = urkf_pkg::mul_b_type'(d_ff);
         end
         urkf_pkg::S_MUL_RAW: begin
            mul_a = urkf_pkg::mul_a_type'(mul_ff + urkf_pkg::RAW_ROUND);
            mul_b = urkf_pkg::mul_b_type'(urkf_pkg::RAW_RECIP);
         end
         urkf_pkg::S_MUL_PH: begin
            mul_a = urkf_pkg::mul_a_type'(cov_ff);
            mul_b = urkf_pkg::mul_b_type'(h_ff);
         end
         urkf_pkg::S_MUL_HH: begin
            mul_a = urkf_pkg::mul_a_type'(h_ff);
            mul_b = urkf_pkg::mul_b_type'(h_ff);
         end
         urkf_pkg::S_MUL_HHP: begin
            mul_a = urkf_pkg::mul_a_type'(mul_ff >> FRAC_BITS);
            mul_b = cov_ff;
         end
         urkf_pkg::S_MUL_HX: begin
            mul_a = urkf_pkg::mul_a_type'(h_ff);
            mul_b = urkf_pkg::mul_b_type'(est_ff);
         end
         urkf_pkg::S_MUL_KMAG: begin
            mul_a = urkf_pkg::mul_a_type'(k_ff);
            mul_b = mag_ff;
         end
         urkf_pkg::S_MUL_KH: begin
            mul_a = urkf_pkg::mul_a_type'(k_ff);
            mul_b = urkf_pkg::mul_b_type'(h_ff);
         end
         urkf_pkg::S_MUL_FP: begin
            mul_a = factor_ff;
            mul_b = cov_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
      mul_in   = mul_full[63:0];
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff[62:0], quo_ff[63]};
      div_ge    = rem_shift >= den_ff;
      rem_next  = div_ge ? rem_shift - den_ff : rem_shift;
      quo_next  = {quo_ff[62:0], div_ge};
      div_last  = div_cnt_ff == '1;
   end

   always_comb begin
      raw_quo  = mul_ff >> urkf_pkg::RAW_RECIP_SHIFT;
      raw_sat  = urkf_pkg::wide_type'(d_ff) >= RAW_SAT_D;
      den_sum  = mul_ff + (urkf_pkg::wide_type'(r_ff) << FRAC_BITS);
      raw_wide = urkf_pkg::wide_type'(raw_ff);
      hx       = mul_ff >> FRAC_BITS;
      diff     = (raw_wide >= hx) ? raw_wide - hx : hx - raw_wide;
      delta    = (mul_ff + GAIN_ROUND) >> urkf_pkg::KF;
      est_wide = urkf_pkg::wide_type'(est_ff);
      est_sum  = est_wide + delta;
      np       = ((mul_ff + COV_ROUND) >> COV_SHIFT) + urkf_pkg::wide_type'(q_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         urkf_pkg::S_IDLE:       if (req_valid) state_in = urkf_pkg::S_MUL_D;
         urkf_pkg::S_MUL_D:      state_in = urkf_pkg::S_MUL_RAW;
         urkf_pkg::S_MUL_RAW:    state_in = urkf_pkg::S_RAW;
         urkf_pkg::S_RAW:        state_in = urkf_pkg::S_MUL_PH;
         urkf_pkg::S_MUL_PH:     state_in = urkf_pkg::S_MUL_HH;
         urkf_pkg::S_MUL_HH:     state_in = urkf_pkg::S_MUL_HHP;
         urkf_pkg::S_MUL_HHP:    state_in = urkf_pkg::S_GAIN_START;
         urkf_pkg::S_GAIN_START: begin
            state_in = (den_sum == '0) ? urkf_pkg::S_MUL_HX : urkf_pkg::S_GAIN_DIV;
         end
         urkf_pkg::S_GAIN_DIV:   if (div_last) state_in = urkf_pkg::S_MUL_HX;
         urkf_pkg::S_MUL_HX:     state_in = urkf_pkg::S_MAG;
         urkf_pkg::S_MAG:        state_in = urkf_pkg::S_MUL_KMAG;
         urkf_pkg::S_MUL_KMAG:   state_in = urkf_pkg::S_EST;
         urkf_pkg::S_EST:        state_in = urkf_pkg::S_MUL_KH;
         urkf_pkg::S_MUL_KH:     state_in = urkf_pkg::S_FACTOR;
         urkf_pkg::S_FACTOR:     state_in = urkf_pkg::S_MUL_FP;
         urkf_pkg::S_MUL_FP:     state_in = urkf_pkg::S_COV;
         urkf_pkg::S_COV:        state_in = urkf_pkg::S_DONE;
         urkf_pkg::S_DONE:       if (!rsp_valid_ff || rsp_ready) state_in = urkf_pkg::S_IDLE;
         default:                state_in = urkf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = state_ff == urkf_pkg::S_IDLE;
      accept     = req_valid && req_ready;
      rsp_load   = (state_ff == urkf_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

      d_in       = d_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      raw_in     = raw_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      div_cnt_in = div_cnt_ff;
      k_in       = k_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      est_in     = est_ff;
      factor_in  = factor_ff;
      cov_in     = cov_ff;

      case (state_ff)
         urkf_pkg::S_IDLE: begin
            if (accept) begin
               d_in     = req_echo_duration_us;
               idx_in   = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         urkf_pkg::S_RAW: begin
            raw_in = (raw_sat || raw_quo > urkf_pkg::wide_type'(urkf_pkg::DIST_MAX)) ?
                     urkf_pkg::DIST_MAX : raw_quo[18:0];
         end
         urkf_pkg::S_MUL_HH: begin
            num_in = mul_ff[47:0];
         end
         urkf_pkg::S_GAIN_START: begin
            rem_in     = '0;
            quo_in     = urkf_pkg::wide_type'(num_ff) << urkf_pkg::KF;
            den_in     = den_sum;
            div_cnt_in = '0;
            if (den_sum == '0) begin
               k_in = '0;
            end
         end
         urkf_pkg::S_GAIN_DIV: begin
            rem_in     = rem_next;
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_last) begin
               k_in = (|quo_next[63:32]) ? '1 : quo_next[31:0];
            end
         end
         urkf_pkg::S_MAG: begin
            neg_in = raw_wide < hx;
            mag_in = (|diff[63:32]) ? '1 : diff[31:0];
         end
         urkf_pkg::S_EST: begin
            if (neg_ff) begin
               est_in = (delta >= est_wide) ? '0 : est_ff - delta[23:0];
            end else begin
               est_in = (est_sum > urkf_pkg::EST_MAX) ? '1 : est_sum[23:0];
            end
         end
         urkf_pkg::S_FACTOR: begin
            factor_in = (mul_ff >= COV_ONE) ? '0 : urkf_pkg::factor_type'(COV_ONE - mul_ff);
         end
         urkf_pkg::S_COV: begin
            cov_in = (|np[63:32]) ? '1 : np[31:0];
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_coll_in  = rsp_coll_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_raw_in   = raw_ff;
         rsp_filt_in  = (urkf_pkg::wide_type'(est_ff) > urkf_pkg::wide_type'(urkf_pkg::DIST_MAX)) ?
                        urkf_pkg::DIST_MAX : est_ff[18:0];
         rsp_coll_in  = raw_ff < thr_ff;
         rsp_idx_in   = idx_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urkf_pkg::S_IDLE;
         count_ff     <= '0;
         est_ff       <= '0;
         cov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         r_ff         <= NOISE_RST;
         q_ff         <= NOISE_RST;
         h_ff         <= H_RST;
         thr_ff       <= THRESH_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
         r_ff         <= r_in;
         q_ff         <= q_in;
         h_ff         <= h_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      idx_ff      <= idx_in;
      raw_ff      <= raw_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      div_cnt_ff  <= div_cnt_in;
      k_ff        <= k_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      factor_ff   <= factor_in;
      mul_ff      <= mul_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_coll_ff <= rsp_coll_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_raw_distance      = rsp_raw_ff;
   assign rsp_filtered_distance = rsp_filt_ff;
   assign rsp_collision_flag    = rsp_coll_ff;
   assign rsp_sample_index      = rsp_idx_ff;

endmodule

// ----- rtl/core/urkf_checker.sv -----
module urkf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input urkf_pkg::idx_type rsp_sample_index,
   input logic              csr_pready
);

   urkf_pkg::idx_type next_idx_ff, next_idx_in;

   assign next_idx_in = (rsp_valid && rsp_ready) ? next_idx_ff + 1'b1 : next_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_idx_ff <= '0;
      end else begin
         next_idx_ff <= next_idx_in;
      end
   end

   a_reset_drops_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_index))
      else $error("stalled result dropped or changed");

   a_index_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_index == next_idx_ff)
      else $error("sample index out of sequence");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind ultrasonic_range_kalman_filter urkf_checker u_urkf_checker (.*);

// ----- sim/tb_ultrasonic_range_kalman_filter.sv -----
module tb_ultrasonic_range_kalman_filter;

   localparam urkf_pkg::csr_data_type REG_TOP [4] = '{32'h00FF_FFFF, 32'h00FF_FFFF,
                                                      32'h0000_FFFF, 32'd285212};
   localparam urkf_pkg::csr_data_type REG_DEFAULT [4] = '{32'd2560, 32'd2560, 32'd256,
                                                          32'd1280};
   localparam logic [15:0] OPENING_ECHOES [10] = '{16'd0, 16'd65535, 16'd1, 16'h8000,
                                                  16'd294, 16'd295, 16'h5555, 16'hAAAA,
                                                  16'd65535, 16'd0};
   localparam int ITEM_TARGET = 1850;

   typedef struct {
      urkf_pkg::dist_type raw;
      urkf_pkg::dist_type filtered;
      logic               collision;
      urkf_pkg::idx_type  index;
   } range_result_type;

   class range_scoreboard;
      localparam int FRAC = 8;

      urkf_pkg::noise_type  noise_r;
      urkf_pkg::noise_type  noise_q;
      logic [15:0]          map_h;
      urkf_pkg::thresh_type threshold;
      urkf_pkg::cov_type    covariance;
      urkf_pkg::est_type    estimate;
      urkf_pkg::idx_type    count;
      range_result_type     pending_ranges[$];
      int failures, checked, zero_gain, est_clamp, factor_clamp, cov_sat, collisions;

      function new();
         noise_r    = urkf_pkg::noise_type'(urkf_pkg::NOISE_RESET << FRAC);
         noise_q    = urkf_pkg::noise_type'(urkf_pkg::NOISE_RESET << FRAC);
         map_h      = 16'(urkf_pkg::H_RESET << FRAC);
         threshold  = urkf_pkg::thresh_type'(urkf_pkg::THRESH_RESET << FRAC);
         covariance = '0;
         estimate   = '0;
         count      = '0;
      endfunction

      function void report(string msg);
         failures++;
         $display("mismatch: %s", msg);
      endfunction

      function void set_reg(urkf_pkg::reg_index_type idx, urkf_pkg::csr_data_type val);
         case (idx)
            urkf_pkg::REG_MEAS_NOISE_R:        noise_r   = val[23:0];
            urkf_pkg::REG_PROCESS_NOISE_Q:     noise_q   = val[23:0];
            urkf_pkg::REG_MEAS_MAP_H:          map_h     = val[15:0];
            urkf_pkg::REG_COLLISION_THRESHOLD: threshold = val[18:0];
            default: ;
         endcase
      endfunction

      function urkf_pkg::csr_data_type reg_value(urkf_pkg::reg_index_type idx);
         case (idx)
            urkf_pkg::REG_MEAS_NOISE_R:    return urkf_pkg::csr_data_type'(noise_r);
            urkf_pkg::REG_PROCESS_NOISE_Q: return urkf_pkg::csr_data_type'(noise_q);
            urkf_pkg::REG_MEAS_MAP_H:      return urkf_pkg::csr_data_type'(map_h);
            default:                       return urkf_pkg::csr_data_type'(threshold);
         endcase
      endfunction

      function range_result_type predict_range(logic [15:0] echo);
         logic [63:0] d, raw, p, h, num, den, k, hx, mag, delta, kh, one, factor, np, est;
         logic neg;
         range_result_type res;
         d   = 64'(echo);
         raw = (((d * 64'd17) << FRAC) + 64'd500) / 64'd1000;
         if (raw > 64'(urkf_pkg::DIST_MAX)) raw = 64'(urkf_pkg::DIST_MAX);
         res.index = count;
         count = count + 1'b1;

         p   = 64'(covariance);
         h   = 64'(map_h);
         num = p * h;
         den = (((h * h) >> FRAC) * p) + (64'(noise_r) << FRAC);
         if (den != 0) begin
            k = (num << urkf_pkg::KF) / den;
         end else begin
            k = '0;
            zero_gain++;
         end
         if (k > 64'h0000_0000_FFFF_FFFF) k = 64'h0000_0000_FFFF_FFFF;

         est = 64'(estimate);
         hx  = (h * est) >> FRAC;
         neg = (raw < hx);
         mag = neg ? hx - raw : raw - hx;
         if (mag > 64'h0000_0000_FFFF_FFFF) mag = 64'h0000_0000_FFFF_FFFF;
         delta = ((k * mag) + (64'd1 << (urkf_pkg::KF - 1))) >> urkf_pkg::KF;
         if (neg) begin
            if (delta >= est) begin
               est = '0;
               est_clamp++;
            end else begin
               est = est - delta;
            end
         end else begin
            est = est + delta;
            if (est > urkf_pkg::EST_MAX) begin
               est = urkf_pkg::EST_MAX;
               est_clamp++;
            end
         end
         estimate = est[23:0];

         kh  = k * h;
         one = 64'd1 << (urkf_pkg::KF + FRAC);
         if (kh >= one) begin
            factor = '0;
            factor_clamp++;
         end else begin
            factor = one - kh;
         end
         np = ((factor * p) + (64'd1 << (urkf_pkg::KF + FRAC - 1))) >> (urkf_pkg::KF + FRAC);
         np = np + 64'(noise_q);
         if (np > 64'h0000_0000_FFFF_FFFF) begin
            np = 64'h0000_0000_FFFF_FFFF;
            cov_sat++;
         end
         covariance = np[31:0];

         res.raw       = raw[18:0];
         res.filtered  = (est > 64'(urkf_pkg::DIST_MAX)) ? urkf_pkg::DIST_MAX : est[18:0];
         res.collision = (raw < 64'(threshold));
         if (res.collision) collisions++;
         return res;
      endfunction

      function void note_echo(logic [15:0] echo);
         pending_ranges.push_back(predict_range(echo));
      endfunction

      function void check_range(urkf_pkg::dist_type raw, urkf_pkg::dist_type filtered,
                                logic collision, urkf_pkg::idx_type index);
         range_result_type want;
         if (pending_ranges.size() == 0) begin
            report($sformatf("result with index %0d arrived with nothing outstanding", index));
            return;
         end
         want = pending_ranges.pop_front();
         checked++;
         if (raw !== want.raw)
            report($sformatf("sample %0d raw distance %0d, expected %0d",
                             want.index, raw, want.raw));
         if (filtered !== want.filtered)
            report($sformatf("sample %0d filtered distance %0d, expected %0d",
                             want.index, filtered, want.filtered));
         if (collision !== want.collision)
            report($sformatf("sample %0d collision flag %b, expected %b",
                             want.index, collision, want.collision));
         if (index !== want.index)
            report($sformatf("sample index %0d, expected %0d", index, want.index));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [15:0]            req_echo_duration_us;
   logic                   rsp_valid;
   logic                   rsp_ready;
   urkf_pkg::dist_type     rsp_raw_distance;
   urkf_pkg::dist_type     rsp_filtered_distance;
   logic                   rsp_collision_flag;
   urkf_pkg::idx_type      rsp_sample_index;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   urkf_pkg::csr_addr_type csr_paddr;
   urkf_pkg::csr_data_type csr_pwdata;
   urkf_pkg::csr_data_type csr_prdata;
   logic                   csr_pready;

   range_scoreboard sb = new();
   int              sent;
   int              stall_left;
   bit              tx_calm;
   bit              rx_calm;
   logic [15:0]     target_echo;

   ultrasonic_range_kalman_filter i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_echo_duration_us  (req_echo_duration_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_filtered_distance (rsp_filtered_distance),
      .rsp_collision_flag    (rsp_collision_flag),
      .rsp_sample_index      (rsp_sample_index),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("watchdog expired after %0d echo transfers", sent);
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_range(rsp_raw_distance, rsp_filtered_distance, rsp_collision_flag,
                        rsp_sample_index);
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 3);
      if (r < 88) return $urandom_range(4, 20);
      if (r < 98) return $urandom_range(21, 80);
      return $urandom_range(100, 400);
   endfunction

   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 7) == 0) stall_left = gap_len();
         end
      end
   end

   function automatic urkf_pkg::csr_data_type pick_reg(urkf_pkg::reg_index_type idx);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return REG_TOP[idx];
         2:       return REG_DEFAULT[idx];
         3:       return $urandom;
         4, 5, 6: return $urandom_range(0, REG_TOP[idx] >> 8);
         default: return $urandom_range(0, REG_TOP[idx]);
      endcase
   endfunction

   function automatic logic [15:0] pick_echo();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 65535);
         1:       v = $urandom_range(0, 1) ? 65535 : 0;
         2:       v = int'(sb.threshold) * 1000 / 4352 + $urandom_range(0, 6) - 3;
         default: v = int'(target_echo) + $urandom_range(0, 128) - 64;
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   task automatic csr_access(bit wr, urkf_pkg::reg_index_type idx,
                             urkf_pkg::csr_data_type val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr)
         sb.set_reg(idx, val);
      else if (csr_prdata !== sb.reg_value(idx))
         sb.report($sformatf("register %0d reads %h, expected %h",
                             idx, csr_prdata, sb.reg_value(idx)));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_regs();
      for (int i = 0; i < 4; i++) csr_access(1'b0, urkf_pkg::reg_index_type'(i), '0);
   endtask

   task automatic send_echo(logic [15:0] echo);
      @(negedge clock);
      req_valid            <= 1'b1;
      req_echo_duration_us <= echo;
      do @(posedge clock); while (!req_ready);
      sb.note_echo(echo);
      sent++;
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending_ranges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic feed(logic [15:0] echo);
      int g;
      send_echo(echo);
      if ($urandom_range(0, 99) == 0) begin
         // hold off until the pipeline is empty
         idle_sender(1);
         drain();
      end else begin
         g = (tx_calm || $urandom_range(0, 2) == 0) ? 0 : gap_len();
         if (g > 0) idle_sender(g);
      end
   endtask

   task automatic run_phase(int n);
      tx_calm     = ($urandom_range(0, 3) == 0);
      rx_calm     = ($urandom_range(0, 3) == 0);
      target_echo = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
      repeat (n) begin
         if ($urandom_range(0, 24) == 0)
            target_echo = $urandom_range(0, 1) ? $urandom_range(0, 3000)
                                               : $urandom_range(0, 65535);
         feed(pick_echo());
      end
      idle_sender(1);
      drain();
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_echo_duration_us = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      sent                 = 0;
      tx_calm              = 1'b0;
      rx_calm              = 1'b0;
      target_echo          = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_regs();
      foreach (OPENING_ECHOES[i]) feed(OPENING_ECHOES[i]);
      idle_sender(1);
      drain();

      // no measurement noise and a tiny map: gain drops to zero
      csr_access(1'b1, urkf_pkg::REG_MEAS_NOISE_R, 32'd0);
      csr_access(1'b1, urkf_pkg::REG_PROCESS_NOISE_Q, 32'h00FF_FFFF);
      csr_access(1'b1, urkf_pkg::REG_MEAS_MAP_H, 32'd8);
      csr_access(1'b1, urkf_pkg::REG_COLLISION_THRESHOLD, 32'd0);
      check_regs();
      feed(16'd0);
      feed(16'd65535);
      feed(16'd300);
      feed(16'd12000);
      feed(16'd65535);
      idle_sender(1);
      drain();
      csr_access(1'b1, urkf_pkg::REG_MEAS_MAP_H, 32'd0);
      feed(16'd40000);
      feed(16'd7);
      idle_sender(1);
      drain();

      // huge covariance against a tiny map: gain saturates, estimate swings rail to rail
      csr_access(1'b1, urkf_pkg::REG_MEAS_NOISE_R, 32'd1);
      csr_access(1'b1, urkf_pkg::REG_MEAS_MAP_H, 32'd1);
      csr_access(1'b1, urkf_pkg::REG_COLLISION_THRESHOLD, 32'd285212);
      check_regs();
      feed(16'd65535);
      feed(16'd0);
      feed(16'd65535);
      feed(16'd30000);
      feed(16'd0);
      idle_sender(1);
      drain();

      // zero map with maximum process noise: covariance climbs to its ceiling
      csr_access(1'b1, urkf_pkg::REG_MEAS_MAP_H, 32'd0);
      csr_access(1'b1, urkf_pkg::REG_PROCESS_NOISE_Q, 32'h00FF_FFFF);
      csr_access(1'b1, urkf_pkg::REG_MEAS_NOISE_R, pick_reg(urkf_pkg::REG_MEAS_NOISE_R));
      check_regs();
      run_phase(280);

      while (sent < ITEM_TARGET) begin
         for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 1))
               csr_access(1'b1, urkf_pkg::reg_index_type'(i),
                          pick_reg(urkf_pkg::reg_index_type'(i)));
         check_regs();
         run_phase($urandom_range(40, 160));
      end

      repeat (300) @(posedge clock);
      if (sb.pending_ranges.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_ranges.size()));

      $display("covered %0d echo transfers, %0d results checked; %0d zero-gain steps,",
               sent, sb.checked, sb.zero_gain);
      $display("%0d estimate clamps, %0d factor clamps, %0d covariance limits, %0d collisions",
               sb.est_clamp, sb.factor_clamp, sb.cov_sat, sb.collisions);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
